// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the LZW decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/lzwvd_pkg.sv =====
// ----------------------------------------------------------------------------
// LZW decoder package
// Types, codes and constants shared by the LZW variable width decoder.
// ----------------------------------------------------------------------------
package lzwvd_pkg;

	localparam int DICT_ENTRIES  = 65536;
	localparam int DICT_AW       = 16;
	localparam int MAX_CODE_BITS = 16;

	localparam logic [16:0] END_CODE   = 17'd256;
	localparam logic [16:0] FIRST_CODE = 17'd257;
	localparam logic [4:0]  MIN_WIDTH  = 5'd9;
	localparam logic [5:0]  HDR_BITS   = 6'd9;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_START = 2'd0;
	localparam cmd_t CMD_BYTE  = 2'd1;
	localparam cmd_t CMD_PULL  = 2'd2;

	typedef logic [2:0] status_t;
	localparam status_t STAT_OK       = 3'd0;
	localparam status_t STAT_BAD_CODE = 3'd1;
	localparam status_t STAT_OVERFLOW = 3'd2;
	localparam status_t STAT_TRUNC    = 3'd3;
	localparam status_t STAT_MISMATCH = 3'd4;
	localparam status_t STAT_REFUSED  = 3'd5;

	typedef struct packed {
		logic [7:0]  sym;
		logic [15:0] link;
	} dict_entry_t;

	typedef struct packed {
		logic [23:0] buffer;
		logic [4:0]  count;
		logic        hdr;
		logic        code_ok;
		logic [15:0] code;
	} unpack_t;

endpackage

// ===== rtl/lzwvd_ifs.sv =====
// ----------------------------------------------------------------------------
// LZW decoder channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lzwvd_in_if import lzwvd_pkg::*; ();
	logic       valid;
	logic       ready;
	cmd_t       cmd;
	logic [7:0] in_byte;
	logic       packet_last;

	modport source (output valid, cmd, in_byte, packet_last, input ready);
	modport sink (input valid, cmd, in_byte, packet_last, output ready);
endinterface

interface lzwvd_out_if import lzwvd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       pending;
	logic       frame_done;
	status_t    status;

	modport source (output valid, out_valid, out_byte, pending, frame_done, status,
		input ready);
	modport sink (input valid, out_valid, out_byte, pending, frame_done, status,
		output ready);
endinterface

interface lzwvd_cfg_if import lzwvd_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [23:0] frame_bytes;

	modport source (output valid, frame_bytes, input ready);
	modport sink (input valid, frame_bytes, output ready);
endinterface

// ===== rtl/lzw_variable_width_decoder.sv =====
// ----------------------------------------------------------------------------
// LZW variable width decoder
// Frame decoder for LSB first packed LZW codes of 9 to 16 bits.
// ----------------------------------------------------------------------------
// One request is handled at a time, and every request returns one result.
// A start request, a refused or ignored byte, an empty pull and a byte that
// completes no code go straight to the response state. A pull request with
// bytes waiting reads the stack top in S_POPW, and a byte whose code ends the
// frame or is bad is resolved in S_START. A byte that decodes a string goes
// through S_START, S_LINK per linked entry, S_TAIL and S_FINISH. The
// dictionary chain is walked one synchronous RAM read per cycle while each
// byte is pushed onto the output stack. A result stays in the output
// register until it is taken, and the next result waits behind it. The RAMs
// need no clearing after reset.
module lzw_variable_width_decoder import lzwvd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lzwvd_in_if.sink    item,
	lzwvd_out_if.source result,
	lzwvd_cfg_if.sink   cfg
);
	`include "assert_macros.svh"

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_START  = 7'b0000010,
		S_LINK   = 7'b0000100,
		S_TAIL   = 7'b0001000,
		S_FINISH = 7'b0010000,
		S_POPW   = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [23:0] frame_bytes_q;
	logic [16:0] stack_cnt_q;
	logic [16:0] next_code_q;
	logic [4:0]  width_q;
	logic [23:0] buf_q;
	logic [4:0]  bcnt_q;
	logic        hdr_q;
	logic [15:0] prev_code_q;
	logic        prev_valid_q;
	logic [7:0]  prev_first_q;
	logic [23:0] decoded_q;
	logic        finished_q;
	status_t     err_q;
	logic [15:0] code_q;
	logic        last_q;
	logic [15:0] cur_q;
	logic [16:0] len_q;
	logic [7:0]  first_q;
	logic        refused_q;
	logic        popv_q;
	logic        rvalid_q;
	logic        r_out_valid_q;
	logic [7:0]  r_out_byte_q;
	logic        r_pending_q;
	logic        r_frame_done_q;
	status_t     r_status_q;

	unpack_t     unp;
	dict_entry_t dict_rd;
	dict_entry_t dict_wd;
	logic        dict_we;
	logic        dict_re;
	logic [15:0] dict_raddr;
	logic        stk_we;
	logic [7:0]  stk_wd;
	logic        stk_re;
	logic [7:0]  stk_rd;
	logic [16:0] width_pow;
	logic        can_add;
	logic        accept;
	logic        slot_free;
	logic [24:0] total;
	logic [16:0] nc_next;

	lzwvd_unpack u_unpack (
		.buffer  (buf_q),
		.count   (bcnt_q),
		.hdr     (hdr_q),
		.width   (width_q),
		.in_byte (item.in_byte),
		.res     (unp)
	);

	lzwvd_ram #(.WIDTH(24), .DEPTH(DICT_ENTRIES)) u_dict (
		.clk   (clk),
		.we    (dict_we),
		.waddr (next_code_q[15:0]),
		.wdata (dict_wd),
		.re    (dict_re),
		.raddr (dict_raddr),
		.rdata (dict_rd)
	);

	lzwvd_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stack_cnt_q[15:0]),
		.wdata (stk_wd),
		.re    (stk_re),
		.raddr (16'(stack_cnt_q - 17'd1)),
		.rdata (stk_rd)
	);

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign cfg.ready  = 1'b1;
	assign slot_free  = !rvalid_q || result.ready;
	assign width_pow  = 17'd1 << width_q;
	assign can_add    = (next_code_q < width_pow) && !next_code_q[16];
	assign total      = 25'(decoded_q) + 25'(len_q);
	assign nc_next    = (prev_valid_q && can_add) ? next_code_q + 17'd1 : next_code_q;
	assign dict_wd    = '{sym: first_q, link: prev_code_q};

	assign result.valid      = rvalid_q;
	assign result.out_valid  = r_out_valid_q;
	assign result.out_byte   = r_out_byte_q;
	assign result.pending    = r_pending_q;
	assign result.frame_done = r_frame_done_q;
	assign result.status     = r_status_q;

	always_comb begin
		dict_we    = 1'b0;
		dict_re    = 1'b0;
		dict_raddr = code_q;
		stk_we     = 1'b0;
		stk_wd     = cur_q[7:0];
		stk_re     = 1'b0;
		case (state_q)
			S_IDLE: begin
				stk_re = accept && item.cmd == CMD_PULL && stack_cnt_q != 17'd0;
			end
			S_START: begin
				if (17'(code_q) < next_code_q && code_q != 16'(END_CODE)) begin
					dict_re = 17'(code_q) > END_CODE;
				end else if (17'(code_q) == next_code_q && prev_valid_q && can_add) begin
					stk_we     = 1'b1;
					stk_wd     = prev_first_q;
					dict_raddr = prev_code_q;
					dict_re    = 17'(prev_code_q) > END_CODE;
				end
			end
			S_LINK: begin
				stk_we     = 1'b1;
				stk_wd     = dict_rd.sym;
				dict_raddr = dict_rd.link;
				dict_re    = 17'(dict_rd.link) > END_CODE;
			end
			S_TAIL: begin
				stk_we = 1'b1;
			end
			S_FINISH: begin
				dict_we = total <= 25'(frame_bytes_q) && prev_valid_q && can_add;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_bytes_q <= 24'd1;
		end else if (cfg.valid && cfg.ready) begin
			frame_bytes_q <= cfg.frame_bytes;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_START) begin
			cur_q <= (17'(code_q) < next_code_q) ? code_q : prev_code_q;
		end else if (state_q == S_LINK) begin
			cur_q <= dict_rd.link;
		end
		if (state_q == S_TAIL)
			first_q <= cur_q[7:0];
		if (accept) begin
			code_q <= unp.code;
			last_q <= item.packet_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			stack_cnt_q    <= '0;
			next_code_q    <= FIRST_CODE;
			width_q        <= MIN_WIDTH;
			buf_q          <= '0;
			bcnt_q         <= '0;
			hdr_q          <= 1'b0;
			prev_code_q    <= '0;
			prev_valid_q   <= 1'b0;
			prev_first_q   <= '0;
			decoded_q      <= '0;
			finished_q     <= 1'b0;
			err_q          <= STAT_OK;
			len_q          <= '0;
			refused_q      <= 1'b0;
			popv_q         <= 1'b0;
			rvalid_q       <= 1'b0;
			r_out_valid_q  <= 1'b0;
			r_out_byte_q   <= '0;
			r_pending_q    <= 1'b0;
			r_frame_done_q <= 1'b0;
			r_status_q     <= STAT_OK;
		end else begin
			if (rvalid_q && result.ready)
				rvalid_q <= 1'b0;
			if (stk_we && !stack_cnt_q[16])
				stack_cnt_q <= stack_cnt_q + 17'd1;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						refused_q <= 1'b0;
						popv_q    <= 1'b0;
						state_q   <= S_RESP;
						case (item.cmd)
							CMD_START: begin
								stack_cnt_q  <= '0;
								next_code_q  <= FIRST_CODE;
								width_q      <= MIN_WIDTH;
								buf_q        <= '0;
								bcnt_q       <= '0;
								hdr_q        <= 1'b0;
								prev_code_q  <= '0;
								prev_valid_q <= 1'b0;
								decoded_q    <= '0;
								finished_q   <= 1'b0;
								err_q        <= STAT_OK;
							end
							CMD_BYTE: begin
								if (stack_cnt_q != 17'd0) begin
									refused_q <= 1'b1;
								end else if (!finished_q && err_q == STAT_OK) begin
									buf_q  <= unp.buffer;
									bcnt_q <= unp.count;
									hdr_q  <= unp.hdr;
									if (unp.code_ok)
										state_q <= S_START;
									else if (item.packet_last)
										err_q <= STAT_TRUNC;
								end
							end
							CMD_PULL: begin
								if (stack_cnt_q != 17'd0) begin
									stack_cnt_q <= stack_cnt_q - 17'd1;
									state_q     <= S_POPW;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_START: begin
					len_q <= '0;
					if (17'(code_q) == END_CODE) begin
						finished_q <= 1'b1;
						if (decoded_q != frame_bytes_q)
							err_q <= STAT_MISMATCH;
						state_q <= S_RESP;
					end else if (17'(code_q) < next_code_q) begin
						state_q <= (17'(code_q) > END_CODE) ? S_LINK : S_TAIL;
					end else if (17'(code_q) == next_code_q && prev_valid_q && can_add) begin
						len_q   <= 17'd1;
						state_q <= (17'(prev_code_q) > END_CODE) ? S_LINK : S_TAIL;
					end else begin
						err_q   <= STAT_BAD_CODE;
						state_q <= S_RESP;
					end
				end
				S_LINK: begin
					len_q <= len_q + 17'd1;
					if (17'(dict_rd.link) <= END_CODE)
						state_q <= S_TAIL;
				end
				S_TAIL: begin
					len_q   <= len_q + 17'd1;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					state_q <= S_RESP;
					if (total > 25'(frame_bytes_q)) begin
						err_q       <= STAT_OVERFLOW;
						stack_cnt_q <= '0;
					end else begin
						decoded_q    <= total[23:0];
						prev_code_q  <= code_q;
						prev_valid_q <= 1'b1;
						prev_first_q <= first_q;
						next_code_q  <= nc_next;
						if (nc_next == width_pow && width_q < 5'(MAX_CODE_BITS))
							width_q <= width_q + 5'd1;
						if (last_q)
							err_q <= STAT_TRUNC;
					end
				end
				S_POPW: begin
					popv_q  <= 1'b1;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (slot_free) begin
						rvalid_q       <= 1'b1;
						r_out_valid_q  <= popv_q;
						r_out_byte_q   <= popv_q ? stk_rd : 8'd0;
						r_pending_q    <= stack_cnt_q != 17'd0;
						r_frame_done_q <= finished_q && err_q == STAT_OK
							&& stack_cnt_q == 17'd0;
						r_status_q     <= refused_q ? STAT_REFUSED : err_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_SAME(a_dict_write_finish, clk, arst_n, dict_we, state_q == S_FINISH && !next_code_q[16])
	`ASSERT_SAME(a_width_range, clk, arst_n, 1'b1, width_q >= MIN_WIDTH && width_q <= 5'(MAX_CODE_BITS))
	`ASSERT_NEXT(a_refuse_pending, clk, arst_n, accept && item.cmd == CMD_BYTE && stack_cnt_q != 17'd0, state_q == S_RESP && refused_q)

endmodule

// ===== rtl/lzwvd_unpack.sv =====
// ----------------------------------------------------------------------------
// LZW bit unpacker
// Appends a byte LSB first, drops the packet header and extracts one code.
// ----------------------------------------------------------------------------
module lzwvd_unpack import lzwvd_pkg::*; (
	input  logic [23:0] buffer,
	input  logic [4:0]  count,
	input  logic        hdr,
	input  logic [4:0]  width,
	input  logic [7:0]  in_byte,
	output unpack_t     res
);
	logic [31:0] acc;
	logic [5:0]  cnt;
	logic        hdr_n;
	logic [31:0] mask;

	always_comb begin
		acc   = 32'(buffer) | (32'(in_byte) << count);
		cnt   = 6'(count) + 6'd8;
		hdr_n = hdr;
		mask  = (32'd1 << width) - 32'd1;
		res.code_ok = 1'b0;
		res.code    = '0;
		if (!hdr_n && cnt >= HDR_BITS) begin
			acc   = acc >> HDR_BITS;
			cnt   = cnt - HDR_BITS;
			hdr_n = 1'b1;
		end
		if (hdr_n && cnt >= 6'(width)) begin
			res.code    = 16'(acc & mask);
			res.code_ok = 1'b1;
			acc         = acc >> width;
			cnt         = cnt - 6'(width);
		end
		res.buffer = acc[23:0];
		res.count  = cnt[4:0];
		res.hdr    = hdr_n;
	end
endmodule

// ===== rtl/lzwvd_ram.sv =====
// ----------------------------------------------------------------------------
// LZW decoder RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lzwvd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ===== verif/lzwvd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZW decoder checker
// Watches the request, result and configuration channels, predicts every
// result of the decoder from its own model, and compares the results in order.
// ----------------------------------------------------------------------------
module lzwvd_checker import lzwvd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lzwvd_in_if        item,
	lzwvd_out_if       result,
	lzwvd_cfg_if       cfg,
	output int         fail_count,
	output int         backlog
);

	typedef struct {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       pending;
		logic       frame_done;
		status_t    status;
	} decoded_t;

	decoded_t    awaited[$];
	logic [7:0]  sym_mem [DICT_ENTRIES];
	logic [15:0] link_mem [DICT_ENTRIES];
	logic [7:0]  byte_stack [DICT_ENTRIES];
	logic [16:0] stack_cnt;
	logic [16:0] free_code;
	logic [4:0]  width;
	logic [31:0] bit_buf;
	logic [4:0]  bit_cnt;
	logic        hdr_done;
	logic [15:0] last_code;
	logic        last_ok;
	logic [23:0] byte_cnt;
	logic        seen_end;
	status_t     err;
	logic [23:0] frame_len;

	function automatic void open_frame();
		stack_cnt = 0;
		free_code = FIRST_CODE;
		width     = MIN_WIDTH;
		bit_buf   = 0;
		bit_cnt   = 0;
		hdr_done  = 0;
		last_code = 0;
		last_ok   = 0;
		byte_cnt  = 0;
		seen_end  = 0;
		err       = STAT_OK;
	endfunction

	function automatic int chain_len(input logic [16:0] c);
		int n;
		n = 1;
		while (c > END_CODE && c < DICT_ENTRIES) begin
			c = 17'(link_mem[c[15:0]]);
			n++;
		end
		return n;
	endfunction

	function automatic void push_stack(input logic [7:0] b);
		if (stack_cnt < DICT_ENTRIES) begin
			byte_stack[stack_cnt[15:0]] = b;
			stack_cnt++;
		end
	endfunction

	function automatic logic [7:0] push_chain(input logic [16:0] c);
		while (c > END_CODE && c < DICT_ENTRIES) begin
			push_stack(sym_mem[c[15:0]]);
			c = 17'(link_mem[c[15:0]]);
		end
		push_stack(c[7:0]);
		return c[7:0];
	endfunction

	function automatic logic room_left();
		return free_code < (17'd1 << width) && free_code < DICT_ENTRIES;
	endfunction

	function automatic void grow_dict(input logic [7:0] s);
		if (last_ok && room_left()) begin
			sym_mem[free_code[15:0]]  = s;
			link_mem[free_code[15:0]] = last_code;
			free_code++;
		end
	endfunction

	function automatic void decode_code(input logic [16:0] code);
		int          len;
		logic [7:0]  first;
		logic [16:0] c;
		if (code == END_CODE) begin
			seen_end = 1;
			if (byte_cnt != frame_len)
				err = STAT_MISMATCH;
			return;
		end
		if (code < free_code) begin
			len = chain_len(code);
			if (byte_cnt + len > frame_len) begin
				err = STAT_OVERFLOW;
				return;
			end
			first = push_chain(code);
			grow_dict(first);
		end else if (code == free_code && last_ok && room_left()) begin
			len = chain_len(17'(last_code)) + 1;
			if (byte_cnt + len > frame_len) begin
				err = STAT_OVERFLOW;
				return;
			end
			c = 17'(last_code);
			while (c > END_CODE && c < DICT_ENTRIES)
				c = 17'(link_mem[c[15:0]]);
			first = c[7:0];
			push_stack(first);
			void'(push_chain(17'(last_code)));
			grow_dict(first);
		end else begin
			err = STAT_BAD_CODE;
			return;
		end
		byte_cnt  = 24'(byte_cnt + len);
		last_code = code[15:0];
		last_ok   = 1;
		if (free_code == (17'd1 << width) && width < MAX_CODE_BITS)
			width++;
	endfunction

	function automatic void take_byte(input logic [7:0] b, input logic last);
		logic [16:0] code;
		bit_buf = bit_buf | (32'(b) << bit_cnt);
		bit_cnt = bit_cnt + 5'd8;
		if (!hdr_done && bit_cnt >= HDR_BITS) begin
			bit_buf  = bit_buf >> HDR_BITS;
			bit_cnt  = 5'(bit_cnt - HDR_BITS);
			hdr_done = 1;
		end
		if (hdr_done && bit_cnt >= width) begin
			code    = 17'(bit_buf & ((32'd1 << width) - 1));
			bit_buf = bit_buf >> width;
			bit_cnt = bit_cnt - width;
			decode_code(code);
		end
		bit_buf = bit_buf & 32'hFFFFFF;
		if (last && !seen_end && err == STAT_OK)
			err = STAT_TRUNC;
	endfunction

	function automatic decoded_t predict(input cmd_t c, input logic [7:0] b, input logic last);
		decoded_t r;
		logic     refused;
		refused     = 0;
		r.out_valid = 0;
		r.out_byte  = 0;
		if (c == CMD_START) begin
			open_frame();
		end else if (c == CMD_BYTE) begin
			if (stack_cnt > 0)
				refused = 1;
			else if (!seen_end && err == STAT_OK)
				take_byte(b, last);
		end else if (c == CMD_PULL) begin
			if (stack_cnt > 0) begin
				stack_cnt--;
				r.out_byte  = byte_stack[stack_cnt[15:0]];
				r.out_valid = 1;
			end
		end
		r.status     = refused ? STAT_REFUSED : err;
		r.pending    = stack_cnt > 0;
		r.frame_done = seen_end && err == STAT_OK && stack_cnt == 0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			open_frame();
			frame_len  = 24'd1;
			fail_count = 0;
			awaited.delete();
			backlog    = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				frame_len = cfg.frame_bytes;
			if (result.valid && result.ready) begin
				if (awaited.size() == 0) begin
					$error("Result arrived with no request waiting for it.");
					fail_count++;
				end else begin
					want = awaited.pop_front();
					if (result.out_valid !== want.out_valid) begin
						$error("out_valid: expected %0d, got %0d", want.out_valid, result.out_valid);
						fail_count++;
					end
					if (result.out_byte !== want.out_byte) begin
						$error("out_byte: expected %0h, got %0h", want.out_byte, result.out_byte);
						fail_count++;
					end
					if (result.pending !== want.pending) begin
						$error("pending: expected %0d, got %0d", want.pending, result.pending);
						fail_count++;
					end
					if (result.frame_done !== want.frame_done) begin
						$error("frame_done: expected %0d, got %0d", want.frame_done,
							result.frame_done);
						fail_count++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						fail_count++;
					end
				end
			end
			if (item.valid && item.ready)
				awaited.push_back(predict(item.cmd, item.in_byte, item.packet_last));
			backlog = awaited.size();
		end
	end

endmodule

// ===== verif/lzw_variable_width_decoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZW variable width decoder testbench
// Encodes directed and random LZW frames into LSB first packets, feeds them
// with pull requests and noise under varying back pressure, and lets the
// checker compare every result against its own prediction.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder_test;
	import lzwvd_pkg::*;

	localparam int WATCHDOG  = 20000;
	localparam int MAX_FRAME = 24'hFFFFFF;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   backlog;
	int   sent;
	int   frames;
	int   damaged;
	int   gap_pct;
	int   stall_pct;
	int   quiet;
	bit   hold_req;

	lzwvd_in_if  item ();
	lzwvd_out_if result ();
	lzwvd_cfg_if cfg ();

	lzw_variable_width_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	lzwvd_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.result     (result),
		.cfg        (cfg),
		.fail_count (fail_count),
		.backlog    (backlog)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready) ||
				(cfg.valid && cfg.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		result.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req     = 0;
				result.ready = 0;
				repeat (300) @(negedge clk);
			end
			result.ready = $urandom_range(99) >= stall_pct;
		end
	end

	task automatic send(input cmd_t c, input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			item.valid = 0;
			@(negedge clk);
		end
		item.valid       = 1;
		item.cmd         = c;
		item.in_byte     = b;
		item.packet_last = last;
		do @(posedge clk); while (!item.ready);
		sent++;
	endtask

	task automatic settle_and_write(input logic [23:0] value);
		@(negedge clk);
		item.valid = 0;
		while (backlog != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg.valid       = 1;
		cfg.frame_bytes = value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 0;
	endtask

	task automatic send_noise();
		case ($urandom_range(2))
			0: send(cmd_t'(2'd3), 8'($urandom), 1'($urandom));
			1: send(CMD_PULL, 8'($urandom), 1'($urandom));
			default: send(CMD_BYTE, 8'($urandom), 1'($urandom));
		endcase
	endtask

	// Damage: 0 none, 1 length off by one, 2 packet cut short, 3 one bit flipped.
	task automatic play_frame(input int fixed[$], input int n_rand, input int cap,
			input int fb_fix, input int damage);
		int  lens[int];
		bit  bits[$];
		int  pulls[$];
		int  nx, w, pv, pc, dec, l, c, r, n, fb, k, steps;
		bit  err, can;
		logic [7:0] b;
		nx  = 257;
		w   = 9;
		pv  = 0;
		pc  = 0;
		dec = 0;
		err = 0;
		repeat (9) bits.push_back(1'($urandom));
		steps = fixed.size() > 0 ? fixed.size() : n_rand + 1;
		for (int i = 0; i < steps; i++) begin
			can = nx < (1 << w) && nx < DICT_ENTRIES;
			if (fixed.size() > 0) begin
				c = fixed[i];
			end else if (i == n_rand) begin
				c = 256;
			end else begin
				r = $urandom_range(99);
				c = $urandom_range(255);
				if (r >= 55 && r < 90 && nx > 257) begin
					k = $urandom_range(257, nx - 1);
					if (lens[k] <= cap)
						c = k;
				end else if (r >= 90 && pv && can && lens.exists(pc) && lens[pc] < cap) begin
					c = nx;
				end else if (r >= 90 && pv && can && pc < 256) begin
					c = nx;
				end
			end
			for (int j = 0; j < w; j++)
				bits.push_back(c[j]);
			l = 0;
			if (!err && c != 256) begin
				if (c < nx)
					l = c < 256 ? 1 : lens[c];
				else if (c == nx && pv && can)
					l = (pc < 256 ? 1 : lens[pc]) + 1;
				else
					err = 1;
				if (!err && fb_fix > 0 && dec + l > fb_fix) begin
					err = 1;
					l   = 0;
				end
				if (!err) begin
					dec = dec + l;
					if (pv && can) begin
						lens[nx] = (pc < 256 ? 1 : lens[pc]) + 1;
						nx++;
					end
					pc = c;
					pv = 1;
					if (nx == (1 << w) && w < MAX_CODE_BITS)
						w++;
				end
			end
			n = (bits.size() + 7) / 8;
			while (pulls.size() < n)
				pulls.push_back(0);
			pulls[n - 1] += err ? 0 : l;
			if (c == 256)
				err = 1;
		end
		while (bits.size() % 8 != 0)
			bits.push_back(1'($urandom));
		n = bits.size() / 8;
		while (pulls.size() < n)
			pulls.push_back(0);
		fb = fb_fix > 0 ? fb_fix : (dec < 1 ? 1 : dec);
		if (damage == 1)
			fb = (fb > 1 && $urandom_range(1)) ? fb - 1 : fb + 1;
		else if (damage == 2 && n > 2)
			n = n - $urandom_range(1, n - 2);
		else if (damage == 3)
			k = $urandom_range(bits.size() - 1);
		if (damage == 3)
			bits[k] = ~bits[k];
		if (damage != 0)
			damaged++;
		settle_and_write(24'(fb));
		frames++;
		send(CMD_START, 8'($urandom), 1'($urandom));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 4)
				send_noise();
			for (int j = 0; j < 8; j++)
				b[j] = bits[8 * i + j];
			send(CMD_BYTE, b, i == n - 1);
			if (pulls[i] > 0 && $urandom_range(99) < 8)
				send(CMD_BYTE, 8'($urandom), 1'($urandom));
			repeat (pulls[i]) send(CMD_PULL, 8'($urandom), 1'($urandom));
		end
		if ($urandom_range(99) < 20)
			send(CMD_BYTE, 8'($urandom), 1'($urandom));
	endtask

	initial begin
		arst_n           = 0;
		item.valid       = 0;
		item.cmd         = CMD_START;
		item.in_byte     = 0;
		item.packet_last = 0;
		cfg.valid        = 0;
		cfg.frame_bytes  = 24'd1;
		sent             = 0;
		frames           = 0;
		damaged          = 0;
		quiet            = 0;
		hold_req         = 0;
		gap_pct          = 14;
		stall_pct        = 64;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send(CMD_PULL, 8'hFF, 1'b1);
		send(cmd_t'(2'd3), 8'h00, 1'b0);
		play_frame('{255, 256}, 0, 0, 1, 0);
		play_frame('{0, 257, 256}, 0, 0, MAX_FRAME, 0);
		play_frame('{65, 300, 256}, 0, 0, 10, 0);
		play_frame('{1, 2, 256}, 0, 0, 1, 0);
		play_frame('{5, 6, 256}, 0, 0, 0, 2);

		hold_req = 1;
		play_frame('{}, 290, 3, 0, 0);
		while (sent < 1600) begin
			if (sent >= 1100) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else if (sent >= 550) begin
				gap_pct   = 64;
				stall_pct = 14;
			end
			if ($urandom_range(99) < 5)
				hold_req = 1;
			play_frame('{}, $urandom_range(2, 30), 12, 0,
				$urandom_range(99) < 80 ? 0 : $urandom_range(1, 3));
		end
		play_frame('{}, 4, 4, 0, 0);
		settle_and_write(24'd1);

		@(negedge clk);
		item.valid = 0;
		while (backlog != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("Sent %0d requests in %0d frames, %0d of them damaged on purpose,",
			sent, frames, damaged);
		$display("with long result hold-offs and three phases of idling on both sides.");
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
